// File: hdl/dcm_pkg.sv
// dcm_pkg: shared constants for the DCM renormalization block.
// No dependencies; used by the top level, the front end, the row lane, the checker and the testbench.
package dcm_pkg;

    // Default element format, signed Q2.14
    localparam int ELEM_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    // Matrix geometry: three rows of three elements
    localparam int ROWS = 3;
    localparam int COLS = 3;

    // Pipeline depth of each part, in register stages
    localparam int FRONT_STAGES = 4;
    localparam int SCALE_STAGES = 4;
    localparam int LATENCY      = FRONT_STAGES + SCALE_STAGES;

endpackage

// File: hdl/dcm_front.sv
// dcm_front: error term, row correction and cross product, four register stages.
// Depends on dcm_pkg for the matrix geometry and stage count.
module dcm_front #(
    parameter int ELEM_WIDTH = dcm_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = dcm_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic signed [ELEM_WIDTH-1:0] x_in [dcm_pkg::COLS],
    input  logic signed [ELEM_WIDTH-1:0] y_in [dcm_pkg::COLS],
    output logic                         out_valid,
    output logic signed [ELEM_WIDTH-1:0] rows_out [dcm_pkg::ROWS][dcm_pkg::COLS]
);

    localparam int W  = ELEM_WIDTH;
    localparam int PW = 2 * W;
    localparam int XW = 2 * W + 4;
    localparam int N  = dcm_pkg::COLS;
    localparam int NS = dcm_pkg::FRONT_STAGES;

    localparam logic signed [XW-1:0] SAT_HI = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] SAT_LO = ~SAT_HI;

    // clamp a wide value to the element range
    function automatic logic signed [W-1:0] sat(input logic signed [XW-1:0] v);
        logic signed [W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[W-1:0];
        else
            r = v[W-1:0];
        return r;
    endfunction

    // valid pipe
    logic [NS-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[NS-2:0], in_valid};
    end

    assign out_valid = vld_reg[NS-1];

    // stage 1: dot lanes and cross lanes
    logic signed [W-1:0]  x_s1_reg [N];
    logic signed [W-1:0]  y_s1_reg [N];
    logic signed [PW-1:0] dot_s1_reg [N];
    logic signed [PW-1:0] cra_s1_reg [N];
    logic signed [PW-1:0] crb_s1_reg [N];

    // stage 2: error term and Z row
    logic signed [W-1:0]  x_s2_reg [N];
    logic signed [W-1:0]  y_s2_reg [N];
    logic signed [W-1:0]  z_s2_reg [N];
    logic signed [W-1:0]  err_s2_reg;
    logic signed [XW-1:0] dot_sum;

    // stage 3: correction products
    logic signed [W-1:0]  x_s3_reg [N];
    logic signed [W-1:0]  y_s3_reg [N];
    logic signed [W-1:0]  z_s3_reg [N];
    logic signed [PW-1:0] cx_s3_reg [N];
    logic signed [PW-1:0] cy_s3_reg [N];

    // stage 4: corrected rows
    logic signed [W-1:0]  rx_s4_reg [N];
    logic signed [W-1:0]  ry_s4_reg [N];
    logic signed [W-1:0]  rz_s4_reg [N];

    assign dot_sum = XW'(dot_s1_reg[0]) + XW'(dot_s1_reg[1]) + XW'(dot_s1_reg[2]);

    always_ff @(posedge clk)
    begin
        err_s2_reg <= sat(dot_sum >>> (FRAC_BITS + 1));
    end

    for (genvar i = 0; i < N; i++)
    begin : g_lane
        localparam int J = (i + 1) % N;
        localparam int K = (i + 2) % N;

        always_ff @(posedge clk)
        begin
            // products of the original rows
            x_s1_reg[i]   <= x_in[i];
            y_s1_reg[i]   <= y_in[i];
            dot_s1_reg[i] <= x_in[i] * y_in[i];
            cra_s1_reg[i] <= x_in[J] * y_in[K];
            crb_s1_reg[i] <= x_in[K] * y_in[J];

            // Z element from the cross product, error reduced above
            x_s2_reg[i] <= x_s1_reg[i];
            y_s2_reg[i] <= y_s1_reg[i];
            z_s2_reg[i] <= sat((XW'(cra_s1_reg[i]) - XW'(crb_s1_reg[i])) >>> FRAC_BITS);

            // error times the other row
            x_s3_reg[i]  <= x_s2_reg[i];
            y_s3_reg[i]  <= y_s2_reg[i];
            z_s3_reg[i]  <= z_s2_reg[i];
            cx_s3_reg[i] <= err_s2_reg * y_s2_reg[i];
            cy_s3_reg[i] <= err_s2_reg * x_s2_reg[i];

            // subtract the correction
            rx_s4_reg[i] <= sat(XW'(x_s3_reg[i]) - (XW'(cx_s3_reg[i]) >>> FRAC_BITS));
            ry_s4_reg[i] <= sat(XW'(y_s3_reg[i]) - (XW'(cy_s3_reg[i]) >>> FRAC_BITS));
            rz_s4_reg[i] <= z_s3_reg[i];
        end

        assign rows_out[0][i] = rx_s4_reg[i];
        assign rows_out[1][i] = ry_s4_reg[i];
        assign rows_out[2][i] = rz_s4_reg[i];
    end

endmodule

// File: hdl/dcm_row_scale.sv
// dcm_row_scale: one row lane, scales a row by (3 - |r|^2)/2 in four stages.
// Depends on dcm_pkg for the row length and stage count.
module dcm_row_scale #(
    parameter int ELEM_WIDTH = dcm_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = dcm_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic signed [ELEM_WIDTH-1:0] row_in [dcm_pkg::COLS],
    output logic                         out_valid,
    output logic signed [ELEM_WIDTH-1:0] row_out [dcm_pkg::COLS]
);

    localparam int W  = ELEM_WIDTH;
    localparam int PW = 2 * W;
    localparam int XW = 2 * W + 4;
    localparam int N  = dcm_pkg::COLS;
    localparam int NS = dcm_pkg::SCALE_STAGES;

    localparam logic signed [XW-1:0] SAT_HI = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [XW-1:0] THREE  = XW'(3) <<< FRAC_BITS;

    // clamp a wide value to the element range
    function automatic logic signed [W-1:0] sat(input logic signed [XW-1:0] v);
        logic signed [W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[W-1:0];
        else
            r = v[W-1:0];
        return r;
    endfunction

    // valid pipe
    logic [NS-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[NS-2:0], in_valid};
    end

    assign out_valid = vld_reg[NS-1];

    logic signed [W-1:0]  r_s5_reg [N];
    logic signed [PW-1:0] sq_s5_reg [N];
    logic signed [W-1:0]  r_s6_reg [N];
    logic signed [W-1:0]  s_s6_reg;
    logic signed [PW-1:0] p_s7_reg [N];
    logic signed [W-1:0]  o_s8_reg [N];
    logic signed [XW-1:0] len;

    // squared length, floored
    assign len = (XW'(sq_s5_reg[0]) + XW'(sq_s5_reg[1]) + XW'(sq_s5_reg[2])) >>> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        s_s6_reg <= sat((THREE - len) >>> 1);
    end

    for (genvar i = 0; i < N; i++)
    begin : g_elem
        always_ff @(posedge clk)
        begin
            r_s5_reg[i]  <= row_in[i];
            sq_s5_reg[i] <= row_in[i] * row_in[i];
            r_s6_reg[i]  <= r_s5_reg[i];
            p_s7_reg[i]  <= s_s6_reg * r_s6_reg[i];
            o_s8_reg[i]  <= sat(XW'(p_s7_reg[i]) >>> FRAC_BITS);
        end

        assign row_out[i] = o_s8_reg[i];
    end

endmodule

// File: hdl/dcm_renormalize.sv
// dcm_renormalize: top level of the DCM renormalization pipeline.
// Depends on dcm_pkg, dcm_front and dcm_row_scale.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------
//  input     | start, busy        | in_xx .. in_zz (9 x signed)
//  result    | done (1-cycle)     | out_xx .. out_zz (9 x signed)
//
// One item per cycle; done and the result come from the last register stage of the row
// lanes: four stages in the front end (products, error/cross, correction products,
// correction) and four in each row lane (squares, scale, scale products, clamp).
// busy stays low: every stage advances every cycle.
// Reset clears only the valid pipe; in-flight items are dropped.
// The receiver has no stall; done pulses once per item.
module dcm_renormalize #(
    parameter int ELEM_WIDTH = dcm_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = dcm_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    output logic                         done,
    input  logic signed [ELEM_WIDTH-1:0] in_xx,
    input  logic signed [ELEM_WIDTH-1:0] in_xy,
    input  logic signed [ELEM_WIDTH-1:0] in_xz,
    input  logic signed [ELEM_WIDTH-1:0] in_yx,
    input  logic signed [ELEM_WIDTH-1:0] in_yy,
    input  logic signed [ELEM_WIDTH-1:0] in_yz,
    input  logic signed [ELEM_WIDTH-1:0] in_zx,
    input  logic signed [ELEM_WIDTH-1:0] in_zy,
    input  logic signed [ELEM_WIDTH-1:0] in_zz,
    output logic signed [ELEM_WIDTH-1:0] out_xx,
    output logic signed [ELEM_WIDTH-1:0] out_xy,
    output logic signed [ELEM_WIDTH-1:0] out_xz,
    output logic signed [ELEM_WIDTH-1:0] out_yx,
    output logic signed [ELEM_WIDTH-1:0] out_yy,
    output logic signed [ELEM_WIDTH-1:0] out_yz,
    output logic signed [ELEM_WIDTH-1:0] out_zx,
    output logic signed [ELEM_WIDTH-1:0] out_zy,
    output logic signed [ELEM_WIDTH-1:0] out_zz
);

    localparam int N = dcm_pkg::COLS;
    localparam int R = dcm_pkg::ROWS;

    logic                         accept;
    logic signed [ELEM_WIDTH-1:0] x_row [N];
    logic signed [ELEM_WIDTH-1:0] y_row [N];
    logic                         front_vld;
    logic signed [ELEM_WIDTH-1:0] mid_rows [R][N];
    logic                         lane_vld [R];
    logic signed [ELEM_WIDTH-1:0] fin_rows [R][N];

    // fully pipelined, never stalls
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // row Z of the input is rebuilt from X and Y, so it is not consumed
    assign x_row[0] = in_xx;
    assign x_row[1] = in_xy;
    assign x_row[2] = in_xz;
    assign y_row[0] = in_yx;
    assign y_row[1] = in_yy;
    assign y_row[2] = in_yz;

    dcm_front #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .x_in      (x_row),
        .y_in      (y_row),
        .out_valid (front_vld),
        .rows_out  (mid_rows)
    );

    // one scaling lane per row
    for (genvar r = 0; r < R; r++)
    begin : g_row
        dcm_row_scale #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_scale (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (front_vld),
            .row_in    (mid_rows[r]),
            .out_valid (lane_vld[r]),
            .row_out   (fin_rows[r])
        );
    end

    // merge lanes: all lanes run in lockstep
    assign done   = lane_vld[0] & lane_vld[1] & lane_vld[2];
    assign out_xx = fin_rows[0][0];
    assign out_xy = fin_rows[0][1];
    assign out_xz = fin_rows[0][2];
    assign out_yx = fin_rows[1][0];
    assign out_yy = fin_rows[1][1];
    assign out_yz = fin_rows[1][2];
    assign out_zx = fin_rows[2][0];
    assign out_zy = fin_rows[2][1];
    assign out_zz = fin_rows[2][2];

endmodule

// File: hdl/dcm_checker.sv
// dcm_checker: port-level assertions for dcm_renormalize, plus its bind.
// Depends on dcm_pkg for the pipeline latency.
module dcm_checker #(
    parameter int ELEM_WIDTH = dcm_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = dcm_pkg::FRAC_BITS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic signed [ELEM_WIDTH-1:0] in_xx,
    input logic signed [ELEM_WIDTH-1:0] in_xy,
    input logic signed [ELEM_WIDTH-1:0] in_xz,
    input logic signed [ELEM_WIDTH-1:0] in_yx,
    input logic signed [ELEM_WIDTH-1:0] in_yy,
    input logic signed [ELEM_WIDTH-1:0] in_yz,
    input logic signed [ELEM_WIDTH-1:0] out_xx,
    input logic signed [ELEM_WIDTH-1:0] out_xy,
    input logic signed [ELEM_WIDTH-1:0] out_xz,
    input logic signed [ELEM_WIDTH-1:0] out_yx,
    input logic signed [ELEM_WIDTH-1:0] out_yy,
    input logic signed [ELEM_WIDTH-1:0] out_yz,
    input logic signed [ELEM_WIDTH-1:0] out_zx,
    input logic signed [ELEM_WIDTH-1:0] out_zy,
    input logic signed [ELEM_WIDTH-1:0] out_zz
);

    localparam int LAT = dcm_pkg::LATENCY;
    localparam logic signed [ELEM_WIDTH-1:0] ONE = ELEM_WIDTH'(1) <<< FRAC_BITS;

    logic acc;
    logic in_zero;
    logic in_ident;
    logic out_zero;
    logic out_ident;

    assign acc       = start & ~busy;
    assign in_zero   = (in_xx == '0) && (in_xy == '0) && (in_xz == '0)
                    && (in_yx == '0) && (in_yy == '0) && (in_yz == '0);
    assign in_ident  = (in_xx == ONE) && (in_xy == '0) && (in_xz == '0)
                    && (in_yx == '0) && (in_yy == ONE) && (in_yz == '0);
    assign out_zero  = (out_xx == '0) && (out_xy == '0) && (out_xz == '0)
                    && (out_yx == '0) && (out_yy == '0) && (out_yz == '0)
                    && (out_zx == '0) && (out_zy == '0) && (out_zz == '0);
    assign out_ident = (out_xx == ONE) && (out_xy == '0) && (out_xz == '0)
                    && (out_yx == '0) && (out_yy == ONE) && (out_yz == '0)
                    && (out_zx == '0) && (out_zy == '0) && (out_zz == ONE);

    // every accepted item yields a result after the fixed latency
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        acc |-> ##LAT done)
        else $error("item accepted without a result after the pipeline latency");

    // no result without an item accepted at the matching edge
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(acc, LAT))
        else $error("result strobe without a matching accepted item");

    // a zero matrix stays zero
    a_zero_maps_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(acc && in_zero, LAT)) |-> out_zero)
        else $error("zero matrix did not renormalize to zero");

    // the identity is already orthonormal
    a_ident_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(acc && in_ident, LAT)) |-> out_ident)
        else $error("identity matrix changed by renormalization");

endmodule

bind dcm_renormalize dcm_checker #(
    .ELEM_WIDTH (ELEM_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
) u_dcm_checker (.*);

// File: verif/tb_dcm_renormalize.sv
// tb_dcm_renormalize: self-checking testbench for the DCM renormalization pipeline.
// Depends on dcm_pkg and dcm_renormalize; predicts every matrix in plain fixed point
// and checks each done pulse against the oldest predicted matrix.
module tb_dcm_renormalize;

    localparam int EW         = dcm_pkg::ELEM_WIDTH_DEF;
    localparam int FB         = dcm_pkg::FRAC_BITS_DEF;
    localparam int ELEMS      = dcm_pkg::ROWS * dcm_pkg::COLS;
    localparam int Q_ONE      = 1 << FB;
    localparam int MAX_CYCLES = 400000;

    // Element 0 is xx, 8 is zz, row by row
    typedef logic [ELEMS-1:0][EW-1:0] mat_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    mat_t drive_mat = '0;
    mat_t result_mat;

    logic signed [EW-1:0] out_xx, out_xy, out_xz;
    logic signed [EW-1:0] out_yx, out_yy, out_yz;
    logic signed [EW-1:0] out_zx, out_zy, out_zz;

    mat_t matrices_to_send[$];
    mat_t renorm_expected[$];
    int   idle_pct   = 0;
    int   n_queued   = 0;
    int   n_accepted = 0;
    int   n_errors   = 0;
    int   n_cycles   = 0;

    string elem_name[ELEMS] = '{"out_xx", "out_xy", "out_xz",
                                "out_yx", "out_yy", "out_yz",
                                "out_zx", "out_zy", "out_zz"};

    dcm_renormalize i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .in_xx  (drive_mat[0]),
        .in_xy  (drive_mat[1]),
        .in_xz  (drive_mat[2]),
        .in_yx  (drive_mat[3]),
        .in_yy  (drive_mat[4]),
        .in_yz  (drive_mat[5]),
        .in_zx  (drive_mat[6]),
        .in_zy  (drive_mat[7]),
        .in_zz  (drive_mat[8]),
        .out_xx (out_xx),
        .out_xy (out_xy),
        .out_xz (out_xz),
        .out_yx (out_yx),
        .out_yy (out_yy),
        .out_yz (out_yz),
        .out_zx (out_zx),
        .out_zy (out_zy),
        .out_zz (out_zz)
    );

    assign result_mat = {out_zz, out_zy, out_zx, out_yz, out_yy, out_yx,
                         out_xz, out_xy, out_xx};

    // Saturate to the signed element range
    function automatic longint clamp_elem(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (EW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Expected renormalized matrix; all sums fit in 64 bits, so >>> is an exact floor
    function automatic mat_t renormalize_dcm(mat_t m);
        longint x[3];
        longint y[3];
        longint r[ELEMS];
        longint err;
        longint len;
        longint s;
        mat_t   res;
        for (int i = 0; i < 3; i++)
        begin
            x[i] = longint'($signed(m[i]));
            y[i] = longint'($signed(m[3 + i]));
        end
        // Half the X.Y dot product
        err = clamp_elem((x[0] * y[0] + x[1] * y[1] + x[2] * y[2]) >>> (FB + 1));
        // Cross-coupled correction from the original rows
        for (int i = 0; i < 3; i++)
        begin
            r[i]     = clamp_elem(x[i] - ((err * y[i]) >>> FB));
            r[3 + i] = clamp_elem(y[i] - ((err * x[i]) >>> FB));
        end
        // Z rebuilt as X cross Y, uncorrected rows
        r[6] = clamp_elem((x[1] * y[2] - x[2] * y[1]) >>> FB);
        r[7] = clamp_elem((x[2] * y[0] - x[0] * y[2]) >>> FB);
        r[8] = clamp_elem((x[0] * y[1] - x[1] * y[0]) >>> FB);
        // Per-row scale by (3 - |r|^2) / 2
        for (int k = 0; k < 3; k++)
        begin
            len = (r[3*k] * r[3*k] + r[3*k+1] * r[3*k+1] + r[3*k+2] * r[3*k+2]) >>> FB;
            s   = clamp_elem(((longint'(3) <<< FB) - len) >>> 1);
            for (int i = 0; i < 3; i++)
                r[3*k + i] = clamp_elem((s * r[3*k + i]) >>> FB);
        end
        for (int i = 0; i < ELEMS; i++)
            res[i] = r[i][EW-1:0];
        return res;
    endfunction

    function automatic mat_t make_mat(int xx, int xy, int xz, int yx, int yy, int yz,
                                      int zx, int zy, int zz);
        mat_t m;
        m[0] = xx[EW-1:0]; m[1] = xy[EW-1:0]; m[2] = xz[EW-1:0];
        m[3] = yx[EW-1:0]; m[4] = yy[EW-1:0]; m[5] = yz[EW-1:0];
        m[6] = zx[EW-1:0]; m[7] = zy[EW-1:0]; m[8] = zz[EW-1:0];
        return m;
    endfunction

    // Any bit pattern, optionally limited to +/-span
    function automatic mat_t random_mat(int span);
        mat_t m;
        int   v;
        for (int i = 0; i < ELEMS; i++)
        begin
            if (span == 0)
                v = int'($urandom);
            else
                v = $urandom_range(0, 2 * span) - span;
            m[i] = v[EW-1:0];
        end
        return m;
    endfunction

    // Signed permutation of the unit matrix plus noise: a drifted rotation
    function automatic mat_t drifted_rotation();
        mat_t m;
        int   col[3];
        int   noise;
        int   v;
        int   sel;
        col[0] = $urandom_range(0, 2);
        col[1] = (col[0] + 1 + $urandom_range(0, 1)) % 3;
        col[2] = 3 - col[0] - col[1];
        sel    = $urandom_range(0, 3);
        noise  = (sel == 0) ? 32 : (sel == 1) ? 600 : (sel == 2) ? 3000 : 9000;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                v = $urandom_range(0, 2 * noise) - noise;
                if (c == col[r])
                    v = v + ($urandom_range(0, 1) ? Q_ONE : -Q_ONE);
                m[3*r + c] = v[EW-1:0];
            end
        end
        return m;
    endfunction

    task automatic queue_matrix(mat_t m);
        matrices_to_send.push_back(m);
        n_queued++;
    endtask

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Driver: presents queued matrices, random idle gaps with junk payload
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                renorm_expected.push_back(renormalize_dcm(drive_mat));
                n_accepted++;
            end
            if (!(start && busy))
            begin
                if (matrices_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    drive_mat <= matrices_to_send.pop_front();
                    start     <= 1'b1;
                end
                else
                begin
                    drive_mat <= random_mat(0);
                    start     <= 1'b0;
                end
            end
        end
    end

    // Monitor: each done pulse against the oldest prediction
    always @(posedge clk)
    begin
        mat_t want;
        if (rst_n && done)
        begin
            if (renorm_expected.size() == 0)
            begin
                n_errors++;
                $error("done with no matrix outstanding");
            end
            else
            begin
                want = renorm_expected.pop_front();
                for (int i = 0; i < ELEMS; i++)
                begin
                    if (result_mat[i] !== want[i])
                    begin
                        n_errors++;
                        $error("%s: expected %0d, actual %0d", elem_name[i],
                               $signed(want[i]), $signed(result_mat[i]));
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > MAX_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin
        int phase_idle[6];
        int sel;
        phase_idle = '{0, 55, 19, 0, 55, 19};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, unit matrices, ignored Z row, saturation paths
        queue_matrix(make_mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_matrix(make_mat(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE));
        queue_matrix(make_mat(Q_ONE, 0, 0, 0, Q_ONE, 0, 32767, -32768, 12345));
        queue_matrix(make_mat(Q_ONE, 0, 0, 0, Q_ONE, 0, -32768, 32767, -1));
        queue_matrix(make_mat(0, -Q_ONE, 0, Q_ONE, 0, 0, 0, 0, -Q_ONE));
        queue_matrix(make_mat(32767, 32767, 32767, 32767, 32767, 32767,
                              32767, 32767, 32767));
        queue_matrix(make_mat(-32768, -32768, -32768, -32768, -32768, -32768,
                              -32768, -32768, -32768));
        queue_matrix(make_mat(32767, 32767, 32767, -32768, -32768, -32768, 0, 0, 0));
        queue_matrix(make_mat(-32768, 32767, -32768, 32767, -32768, 32767,
                              -32768, 32767, -32768));
        queue_matrix(make_mat(Q_ONE, Q_ONE, 0, Q_ONE, Q_ONE, 0, 0, 0, 0));
        queue_matrix(make_mat(-1, -1, -1, -1, -1, -1, -1, -1, -1));
        queue_matrix(make_mat(1, 1, 1, 1, 1, 1, 1, 1, 1));
        queue_matrix(make_mat(1, 0, 0, 0, 1, 0, 0, 0, 1));
        queue_matrix(make_mat(Q_ONE / 2, 0, 0, 0, Q_ONE / 2, 0, 0, 0, Q_ONE / 2));
        queue_matrix(make_mat(11585, 11585, 0, -11585, 11585, 0, 0, 0, Q_ONE));
        queue_matrix(make_mat(Q_ONE + 800, 300, -200, -250, Q_ONE - 700, 150, 0, 0, 0));
        queue_matrix(make_mat(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
        queue_matrix(make_mat(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
        queue_matrix(make_mat(20000, 20000, 0, 20000, -20000, 0, 0, 0, 0));
        queue_matrix(make_mat(21845, 0, 0, 0, 21845, 0, 0, 0, 0));
        queue_matrix(make_mat(32767, -32768, 32767, 32767, -32768, 32767, 5, 6, 7));

        // Random phases with different idle rates
        for (int p = 0; p < 6; p++)
        begin
            while (n_accepted != n_queued)
                @(posedge clk);
            idle_pct = phase_idle[p];
            for (int n = 0; n < 140; n++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 60)
                    queue_matrix(drifted_rotation());
                else if (sel < 85)
                    queue_matrix(random_mat(0));
                else
                    queue_matrix(random_mat(Q_ONE));
            end
        end

        // Drain: all sent, all checked, then an idle tail before the end of the run
        while (n_accepted != n_queued)
            @(posedge clk);
        while (renorm_expected.size() != 0)
            @(posedge clk);
        repeat (dcm_pkg::LATENCY * 4) @(posedge clk);

        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
